/* rtl/epf_pkg.sv */
package epf_pkg;

   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

endpackage

/* rtl/epf_if.sv */
interface epf_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] now_time;
   logic [7:0]  msg_type;
   logic [7:0]  iface_index;
   logic [15:0] packet_handle;

   modport source (output valid, req_type, now_time, msg_type, iface_index, packet_handle,
                   input ready);
   modport sink   (input valid, req_type, now_time, msg_type, iface_index, packet_handle,
                   output ready);
endinterface

interface epf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  out_msg_type;
   logic [7:0]  out_iface;
   logic [15:0] out_handle;
   logic [31:0] waited_time;

   modport source (output valid, status, out_msg_type, out_iface, out_handle, waited_time,
                   input ready);
   modport sink   (input valid, status, out_msg_type, out_iface, out_handle, waited_time,
                   output ready);
endinterface

interface epf_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/expiring_packet_fifo_core.sv */
// Expiring packet descriptor FIFO.
// req_ch: one request per handshake; req_type selects enqueue or dequeue, now_time
//   is the current tick count, the descriptor fields matter only on enqueue.
// rsp_ch: exactly one response per request, in request order.
// csr_ch: writes the expiry timeout; each enqueued entry keeps the value in force
//   when it was stored. Write only while no request is in flight.
// Timing: a request is taken in idle, the head entry is read from the descriptor
//   RAM into a read register and evaluated the next cycle. Enqueue and a dequeue
//   that hits a live head respond from that evaluation; each expired head skipped
//   on dequeue is discarded and costs one RAM read of the new head.
// The response sits in an output register, so the next request is taken while a
//   response still waits. If the receiver stalls and that register is occupied,
//   the block holds in evaluation until the register frees up.
// Reset: queue empty, pointers zero, timeout 1000. The RAMs are not cleared;
//   only entries between head and tail are ever used.
module expiring_packet_fifo_core (
   input  logic      clock,
   input  logic      reset,
   epf_req_if.sink   req_ch,
   epf_rsp_if.source rsp_ch,
   epf_csr_if.sink   csr_ch
);
   import epf_pkg::*;

   // descriptor RAMs: {msg_type, iface, handle} and {arrival, timeout}
   logic [31:0] info_mem  [DEPTH];
   logic [63:0] times_mem [DEPTH];
   logic [31:0] rd_info_ff;
   logic [63:0] rd_times_ff;

   state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      timeout_ff;

   // latched request
   req_kind_type rq_kind_ff;
   logic [31:0]  rq_now_ff;
   logic [7:0]   rq_msg_ff, rq_iface_ff;
   logic [15:0]  rq_handle_ff;

   // response register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_msg_ff, rsp_iface_ff;
   logic [15:0] rsp_handle_ff;
   logic [31:0] rsp_waited_ff;

   logic        req_accept, out_free, rsp_load, wr_en, is_full, expired;
   logic [31:0] age;
   status_type  status_in;
   logic        fields_in;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign age        = rq_now_ff - rd_times_ff[63:32];
   assign expired    = age > rd_times_ff[31:0];
   assign is_full    = count_ff == CNT_FULL;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_EVAL;
         ST_EVAL: if (rsp_load)   state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      req_ch.ready = state_ff == ST_IDLE;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      status_in    = STATUS_DONE;
      fields_in    = 1'b0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      if (state_ff == ST_EVAL) begin
         if (rq_kind_ff == REQ_ENQUEUE) begin
            if (is_full && !expired) begin
               if (out_free) begin
                  rsp_load  = 1'b1;
                  status_in = STATUS_FULL;
               end
            end else if (out_free) begin
               rsp_load = 1'b1;
               wr_en    = 1'b1;
               tail_in  = next_slot(tail_ff);
               if (is_full) head_in  = next_slot(head_ff);   // expired head dropped
               else         count_in = count_ff + 1'b1;
            end
         end else begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_load  = 1'b1;
                  status_in = STATUS_EMPTY;
               end
            end else if (expired) begin
               // discard and re-read the new head next cycle
               head_in  = next_slot(head_ff);
               count_in = count_ff - 1'b1;
            end else if (out_free) begin
               rsp_load  = 1'b1;
               fields_in = 1'b1;
               head_in   = next_slot(head_ff);
               count_in  = count_ff - 1'b1;
            end
         end
      end
   end

   // RAMs: read always follows the next head; writes only happen in the cycle
   // before returning to idle, so no read is in flight on a written slot
   always_ff @(posedge clock) begin
      rd_info_ff  <= info_mem[head_in];
      rd_times_ff <= times_mem[head_in];
      if (wr_en) begin
         info_mem[tail_ff]  <= {rq_msg_ff, rq_iface_ff, rq_handle_ff};
         times_mem[tail_ff] <= {rq_now_ff, timeout_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         timeout_ff <= 32'd1000;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (csr_ch.valid && csr_ch.ready) timeout_ff <= csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rq_kind_ff   <= req_kind_type'(req_ch.req_type);
         rq_now_ff    <= req_ch.now_time;
         rq_msg_ff    <= req_ch.msg_type;
         rq_iface_ff  <= req_ch.iface_index;
         rq_handle_ff <= req_ch.packet_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_msg_ff    <= fields_in ? rd_info_ff[31:24] : 8'd0;
         rsp_iface_ff  <= fields_in ? rd_info_ff[23:16] : 8'd0;
         rsp_handle_ff <= fields_in ? rd_info_ff[15:0]  : 16'd0;
         rsp_waited_ff <= fields_in ? age               : 32'd0;
      end
   end

   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_msg_type = rsp_msg_ff;
   assign rsp_ch.out_iface    = rsp_iface_ff;
   assign rsp_ch.out_handle   = rsp_handle_ff;
   assign rsp_ch.waited_time  = rsp_waited_ff;

   // occupancy never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above depth");

   // tail always sits count entries past head on the ring
   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, tail_ff} + (CNT_W + 1)'(0) == {1'b0, head_ff} + count_ff) ||
      ({1'b0, tail_ff} + (CNT_W + 1)'(DEPTH) == {1'b0, head_ff} + count_ff))
      else $error("head, tail and count disagree");

   // empty is reported only for an empty queue
   a_empty_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_in == STATUS_EMPTY) |-> count_ff == '0)
      else $error("empty status with entries present");

   // a finished request frees the request side in the following cycle
   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> req_ch.ready && rsp_valid_ff)
      else $error("response load did not return to idle");

   // a rejected enqueue leaves the queue untouched
   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_in == STATUS_FULL) |=>
         (count_ff == $past(count_ff) && tail_ff == $past(tail_ff) &&
          head_ff == $past(head_ff)))
      else $error("rejected enqueue modified the queue");

endmodule

/* test/expiring_packet_fifo_core_tb.sv */
module expiring_packet_fifo_core_tb;
   import epf_pkg::*;

   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   // long receiver hold-off used to back the block up into its request side
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 100;

   typedef struct {
      req_kind_type kind;
      logic [31:0]  now;
      logic [7:0]   msg;
      logic [7:0]   ifc;
      logic [15:0]  hdl;
   } fifo_request_type;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  msg;
      logic [7:0]  ifc;
      logic [15:0] hdl;
      logic [31:0] waited;
   } fifo_response_type;

   typedef struct {
      logic [7:0]  msg;
      logic [7:0]  ifc;
      logic [15:0] hdl;
      logic [31:0] arrival;
      logic [31:0] limit;
   } stored_entry_type;

   // Shadow copy of the descriptor queue; predicts one response per request
   // and checks responses in order.
   class expiry_fifo_model;
      logic [31:0]       timeout;
      stored_entry_type  slots [DEPTH];
      int                head;
      int                tail;
      int                count;
      fifo_response_type awaited [$];
      int                errors;

      function new();
         timeout = 32'd1000;
         head    = 0;
         tail    = 0;
         count   = 0;
         errors  = 0;
      endfunction

      function void set_timeout(logic [31:0] value);
         timeout = value;
      endfunction

      function logic [31:0] head_age(logic [31:0] now);
         logic [31:0] age;
         age = now - slots[head].arrival;
         return age;
      endfunction

      function void pop_head();
         head  = (head + 1) % DEPTH;
         count = count - 1;
      endfunction

      function void predict_response(fifo_request_type r);
         fifo_response_type e;
         stored_entry_type  cur;
         logic [31:0]       age;
         bit                dead;
         bit                found;
         e.status = STATUS_DONE;
         e.msg    = '0;
         e.ifc    = '0;
         e.hdl    = '0;
         e.waited = '0;
         if (r.kind == REQ_ENQUEUE) begin
            if (count >= DEPTH) begin
               // full: an expired head makes room, a live one blocks the enqueue
               if (head_age(r.now) > slots[head].limit) begin
                  pop_head();
               end else begin
                  e.status = STATUS_FULL;
                  awaited.push_back(e);
                  return;
               end
            end
            slots[tail] = '{msg: r.msg, ifc: r.ifc, hdl: r.hdl,
                            arrival: r.now, limit: timeout};
            tail  = (tail + 1) % DEPTH;
            count = count + 1;
         end else begin
            found = 0;
            while (count > 0 && !found) begin
               age  = head_age(r.now);
               dead = age > slots[head].limit;
               cur  = slots[head];
               pop_head();
               if (!dead) begin
                  e.msg    = cur.msg;
                  e.ifc    = cur.ifc;
                  e.hdl    = cur.hdl;
                  e.waited = age;
                  found    = 1;
               end
            end
            if (!found) e.status = STATUS_EMPTY;
         end
         awaited.push_back(e);
      endfunction

      function void check_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 40)
               $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
         end
      endfunction

      function void compare_response(fifo_response_type got);
         fifo_response_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: response with none outstanding, expected none actual status %h",
                        $time, got.status);
            return;
         end
         want = awaited.pop_front();
         check_field("status",       32'(want.status), 32'(got.status));
         check_field("out_msg_type", 32'(want.msg),    32'(got.msg));
         check_field("out_iface",    32'(want.ifc),    32'(got.ifc));
         check_field("out_handle",   32'(want.hdl),    32'(got.hdl));
         check_field("waited_time",  want.waited,      got.waited);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   epf_req_if req_bus ();
   epf_rsp_if rsp_bus ();
   epf_csr_if csr_bus ();

   expiring_packet_fifo_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   expiry_fifo_model sb;

   bit steady;          // no idling on either side
   bit hold_request;    // asks the receiver for one long hold-off
   int sender_burst;    // requests still to be offered back to back
   int idle_cycles;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady) return 0;
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // optional idle gap, then one request held until it is taken
   task automatic send_request(req_kind_type kind, logic [31:0] now, logic [7:0] msg,
                               logic [7:0] ifc, logic [15:0] hdl, int gap);
      fifo_request_type r;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.req_type      = kind;
      req_bus.now_time      = now;
      req_bus.msg_type      = msg;
      req_bus.iface_index   = ifc;
      req_bus.packet_handle = hdl;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = '{kind: kind, now: now, msg: msg, ifc: ifc, hdl: hdl};
      sb.predict_response(r);
   endtask

   task automatic drain_queue();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.data  = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.set_timeout(value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // receiver: ready driven at the falling edge, responses taken at the rising edge
   initial begin : receiver
      int stall_left;
      int roll;
      bit hold_seen;
      fifo_response_type got;
      stall_left    = 0;
      hold_seen     = 0;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request && !hold_seen) begin
            stall_left = HOLD_CYCLES;
            hold_seen  = 1;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            roll = $urandom_range(0, 99);
            if (!steady) begin
               if (roll >= 95) stall_left = $urandom_range(10, 40);
               else if (roll >= 70) stall_left = $urandom_range(1, 3);
            end
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status = rsp_bus.status;
            got.msg    = rsp_bus.out_msg_type;
            got.ifc    = rsp_bus.out_iface;
            got.hdl    = rsp_bus.out_handle;
            got.waited = rsp_bus.waited_time;
            sb.compare_response(got);
         end
      end
   end

   // hang detector: any handshake on any channel resets the count
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [31:0]  now_ticks;
      logic [31:0]  tmo;
      logic [31:0]  step_max;
      req_kind_type kind;
      int           enq_pct;
      sb            = new();
      steady        = 0;
      hold_request  = 0;
      sender_burst  = 0;
      reset         = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = 1'b0;
      req_bus.now_time      = '0;
      req_bus.msg_type      = '0;
      req_bus.iface_index   = '0;
      req_bus.packet_handle = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.data          = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, reset timeout of 1000 ticks
      send_request(REQ_DEQUEUE, 32'd0, 8'h00, 8'h00, 16'h0000, 0);   // empty queue
      // field extremes; first arrival sits just before the time wrap
      send_request(REQ_ENQUEUE, 32'hFFFF_FFF0, 8'hFF, 8'h00, 16'hFFFF, 0);
      send_request(REQ_ENQUEUE, 32'd5, 8'h00, 8'hFF, 16'h0000, 0);
      send_request(REQ_DEQUEUE, 32'h0000_0010, 8'hAA, 8'h55, 16'h1234, 0); // wrapped age
      send_request(REQ_DEQUEUE, 32'd6, 8'h00, 8'h00, 16'h0000, 0);
      for (int i = 0; i < DEPTH; i++)
         send_request(REQ_ENQUEUE, 32'd100 + i, 8'(i), ~8'(i), 16'($urandom), 0);
      send_request(REQ_ENQUEUE, 32'd200, 8'h11, 8'h22, 16'h3333, 0);  // full, head live
      send_request(REQ_ENQUEUE, 32'd1200, 8'h44, 8'h55, 16'h6666, 0); // full, head expired
      send_request(REQ_DEQUEUE, 32'd1105, 8'h00, 8'h00, 16'h0000, 0); // skips four
      send_request(REQ_DEQUEUE, 32'd5000, 8'h00, 8'h00, 16'h0000, 0); // all expired

      now_ticks = $urandom;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_queue();
         case (ph)
            0:       tmo = 32'd0;
            1:       tmo = 32'hFFFF_FFFF;
            2:       tmo = 32'd40;
            3:       tmo = $urandom_range(1, 200);
            4:       tmo = $urandom;
            5:       tmo = 32'd12;
            6:       tmo = $urandom_range(200, 5000);
            default: tmo = 32'd1;
         endcase
         write_timeout(tmo);
         steady   = (ph == 3 || ph == 6);
         enq_pct  = $urandom_range(45, 72);
         step_max = (tmo < 32'd4000) ? tmo / 3 + 2 : 32'd3000;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 30) begin
               hold_request = 1;
               sender_burst = 40;
            end
            // mostly forward time, now and then an arbitrary jump
            if ($urandom_range(0, 29) == 0)
               now_ticks = $urandom;
            else
               now_ticks = now_ticks + $urandom_range(0, step_max);
            kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
            send_request(kind, now_ticks, 8'($urandom), 8'($urandom), 16'($urandom),
                         pick_gap());
         end
      end

      steady = 0;
      drain_queue();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
